@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared clocked assertion forms used by the match marker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising edge outside reset.
`define NNM_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// The condition must never be true at a rising edge outside reset.
`define NNM_ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error(msg);

`endif

@@ hdl/nnm_pkg.sv @@
// ----------------------------------------------------------------------------
// Match marker package
// Field widths, codes, control structs and width helpers for the match marker.
// ----------------------------------------------------------------------------
package nnm_pkg;

  localparam int TABLE_DEPTH_DEF = 1024;
  localparam int VALUE_BITS_DEF  = 32;
  localparam int MAX_SIDE_DEF    = 16;

  localparam int REQ_TYPE_W  = 2;
  localparam int SAMPLE_W    = 32;
  localparam int ID_W        = 31;
  localparam int NEAREST_W   = 10;
  localparam int SIDE_W      = 5;
  localparam int LENGTH_W    = 11;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 11;
  localparam int MARK_BIT_MAX = 5;

  localparam logic [REQ_TYPE_W-1:0] REQ_LOAD  = 2'd0;
  localparam logic [REQ_TYPE_W-1:0] REQ_QUERY = 2'd1;
  localparam logic [REQ_TYPE_W-1:0] REQ_DRAIN = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] CFG_LEFT   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_RIGHT  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_LENGTH = 2'd2;

  localparam logic RES_QUERY = 1'b0;
  localparam logic RES_DRAIN = 1'b1;

  localparam logic [SIDE_W-1:0]   LEFT_RESET   = 5'd2;
  localparam logic [SIDE_W-1:0]   RIGHT_RESET  = 5'd2;
  localparam logic [LENGTH_W-1:0] LENGTH_RESET = 11'd0;

  typedef struct packed {
    logic start;
    logic run;
  } scan_ctl_t;

  typedef struct packed {
    logic stop;
    logic tie;
  } scan_stat_t;

  function automatic int idx_width(int depth);
    int w;
    w = $clog2(depth);
    return (w > 2) ? w : 2;
  endfunction

  function automatic int bit_width(int depth);
    int w;
    w = idx_width(depth) - 1;
    return (w < MARK_BIT_MAX) ? w : MARK_BIT_MAX;
  endfunction

endpackage

@@ hdl/nnm_entry_ram.sv @@
// ----------------------------------------------------------------------------
// Entry memory
// Control values and ids, one write port and one registered read port.
// ----------------------------------------------------------------------------
module nnm_entry_ram #(
  parameter int DEPTH      = nnm_pkg::TABLE_DEPTH_DEF,
  parameter int IDX_W      = 10,
  parameter int VALUE_BITS = nnm_pkg::VALUE_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [IDX_W-1:0]          waddr,
  input  logic [VALUE_BITS-1:0]     wvalue,
  input  logic [nnm_pkg::ID_W-1:0]  wid,
  input  logic                      re,
  input  logic [IDX_W-1:0]          raddr,
  output logic [VALUE_BITS-1:0]     rvalue,
  output logic [nnm_pkg::ID_W-1:0]  rid
);
  import nnm_pkg::*;

  logic [VALUE_BITS-1:0] value_mem [DEPTH];
  logic [ID_W-1:0]       id_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      value_mem[waddr] <= wvalue;
      id_mem[waddr]    <= wid;
    end
    if (re) begin
      rvalue <= value_mem[raddr];
      rid    <= id_mem[raddr];
    end
  end

endmodule

@@ hdl/nnm_mark_ram.sv @@
// ----------------------------------------------------------------------------
// Mark memory
// Match marks packed in rows, with a clearing pass over all rows after reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nnm_mark_ram #(
  parameter int ROW_W  = 5,
  parameter int MARK_W = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              we,
  input  logic [ROW_W-1:0]  waddr,
  input  logic [MARK_W-1:0] wdata,
  input  logic              re,
  input  logic [ROW_W-1:0]  raddr,
  output logic [MARK_W-1:0] rdata,
  output logic              busy
);
  import nnm_pkg::*;

  logic [MARK_W-1:0] mem [1 << ROW_W];
  logic [ROW_W-1:0]  clr_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b1;
      clr_row <= '0;
    end else if (busy) begin
      clr_row <= clr_row + 1'b1;
      if (clr_row == '1) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_row] <= '0;
    end else if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  `NNM_ASSERT_NEVER(a_no_write_in_clear, clk, rst, busy && we, "mark write during clearing pass")

endmodule

@@ hdl/nnm_scan.sv @@
// ----------------------------------------------------------------------------
// Nearest scan unit
// Streams entries from index zero, keeps the best distance, stops on growth or at the end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nnm_scan #(
  parameter int IDX_W      = 10,
  parameter int VALUE_BITS = nnm_pkg::VALUE_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  nnm_pkg::scan_ctl_t      ctl,
  input  logic [IDX_W:0]          len,
  input  logic [VALUE_BITS-1:0]   query,
  input  logic [VALUE_BITS-1:0]   rvalue,
  output logic                    rd_en,
  output logic [IDX_W-1:0]        rd_addr,
  output nnm_pkg::scan_stat_t     stat,
  output logic [IDX_W-1:0]        nearest,
  output logic [IDX_W-1:0]        first_tie
);
  import nnm_pkg::*;

  logic [IDX_W:0]        issue_cnt;
  logic                  rd_v;
  logic [IDX_W-1:0]      rd_idx;
  logic [VALUE_BITS-1:0] q_b;
  logic [VALUE_BITS-1:0] r_b;
  logic [VALUE_BITS-1:0] dist_next;
  logic                  v1;
  logic [VALUE_BITS-1:0] d1;
  logic [IDX_W-1:0]      idx1;
  logic                  have;
  logic                  tie;
  logic [VALUE_BITS-1:0] best;
  logic                  accept;
  logic                  brk;

  assign r_b       = {~rvalue[VALUE_BITS-1], rvalue[VALUE_BITS-2:0]};
  assign dist_next = (q_b >= r_b) ? (q_b - r_b) : (r_b - q_b);
  assign accept    = !have || (d1 < best) || ((d1 == '0) && (best == '0));
  assign brk       = !accept && (d1 > best);
  assign rd_en     = ctl.run && (issue_cnt < len);
  assign rd_addr   = issue_cnt[IDX_W-1:0];
  assign stat.stop = ctl.run && ((v1 && brk) || ((issue_cnt == len) && !rd_v && !v1));
  assign stat.tie  = tie;

  always_ff @(posedge clk) begin
    if (rst) begin
      issue_cnt <= '0;
      rd_v      <= 1'b0;
      v1        <= 1'b0;
      have      <= 1'b0;
      tie       <= 1'b0;
    end else if (ctl.start) begin
      issue_cnt <= '0;
      rd_v      <= 1'b0;
      v1        <= 1'b0;
      have      <= 1'b0;
      tie       <= 1'b0;
    end else begin
      rd_v <= rd_en;
      if (rd_en) begin
        issue_cnt <= issue_cnt + 1'b1;
      end
      v1 <= rd_v && ctl.run;
      if (ctl.run && v1 && accept) begin
        have <= 1'b1;
        if (d1 == '0) begin
          tie <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      q_b <= {~query[VALUE_BITS-1], query[VALUE_BITS-2:0]};
    end
    rd_idx <= issue_cnt[IDX_W-1:0];
    if (rd_v) begin
      d1   <= dist_next;
      idx1 <= rd_idx;
    end
    if (ctl.run && v1 && accept) begin
      best    <= d1;
      nearest <= idx1;
      if ((d1 == '0) && !tie) begin
        first_tie <= idx1;
      end
    end
  end

  `NNM_ASSERT(a_stage_order, clk, rst, v1 |-> $past(rd_v), "distance stage valid without a read")

endmodule

@@ hdl/nearest_neighbor_match_marker_unit.sv @@
// ----------------------------------------------------------------------------
// Nearest neighbor match marker
// Sorted control table with match marks: load, nearest query, drain of marks.
// ----------------------------------------------------------------------------
//  Channel   Handshake            Payload
//  request   req_valid/req_stall  req_type, sample_value, entry_id
//  result    rsp_valid/rsp_stall  result_kind, nearest_index, match_id,
//                                 match_valid, last_match
//  config    cfg_we               cfg_index, cfg_data
//
// A load writes the next entry and gives no result. A query scans until the
// distance grows or the length ends, then reads and rewrites each mark row
// in the neighbor range. A drain searches the mark rows for the next mark.
// After reset a clearing pass over every mark row (32 rows at the default
// depth) runs while requests are stalled. A result held in the output
// register stalls requests only once the next result is ready behind it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nearest_neighbor_match_marker_unit #(
  parameter int TABLE_DEPTH = nnm_pkg::TABLE_DEPTH_DEF,
  parameter int VALUE_BITS  = nnm_pkg::VALUE_BITS_DEF,
  parameter int MAX_SIDE    = nnm_pkg::MAX_SIDE_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 req_valid,
  output logic                                 req_stall,
  input  logic [nnm_pkg::REQ_TYPE_W-1:0]       req_type,
  input  logic signed [nnm_pkg::SAMPLE_W-1:0]  sample_value,
  input  logic [nnm_pkg::ID_W-1:0]             entry_id,
  output logic                                 rsp_valid,
  input  logic                                 rsp_stall,
  output logic                                 result_kind,
  output logic [nnm_pkg::NEAREST_W-1:0]        nearest_index,
  output logic [nnm_pkg::ID_W-1:0]             match_id,
  output logic                                 match_valid,
  output logic                                 last_match,
  input  logic                                 cfg_we,
  input  logic [nnm_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [nnm_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import nnm_pkg::*;

  localparam int IDX_W  = idx_width(TABLE_DEPTH);
  localparam int BIT_W  = bit_width(TABLE_DEPTH);
  localparam int ROW_W  = IDX_W - BIT_W;
  localparam int MARK_W = 1 << BIT_W;
  localparam int LEN_W  = IDX_W + 1;
  localparam int LW     = (LEN_W > LENGTH_W) ? LEN_W : LENGTH_W;
  localparam int EW     = ((IDX_W > 7) ? IDX_W : 7) + 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

  typedef enum logic [7:0] {
    ST_IDLE    = 8'b0000_0001,
    ST_SCAN    = 8'b0000_0010,
    ST_RANGE   = 8'b0000_0100,
    ST_MARK_RD = 8'b0000_1000,
    ST_MARK_WR = 8'b0001_0000,
    ST_FIND    = 8'b0010_0000,
    ST_MORE    = 8'b0100_0000,
    ST_RESULT  = 8'b1000_0000
  } state_t;

  state_t state;

  logic [SIDE_W-1:0]   left_neighbors;
  logic [SIDE_W-1:0]   right_neighbors;
  logic [LENGTH_W-1:0] table_length;
  logic [IDX_W-1:0]    load_ptr;
  logic [ROW_W-1:0]    drain_row;

  logic [LEN_W-1:0]    len;
  logic [IDX_W-1:0]    lo;
  logic [IDX_W-1:0]    hi;
  logic [ROW_W-1:0]    row;
  logic                res_kind;
  logic [IDX_W-1:0]    res_idx;
  logic                res_found;
  logic                res_more;

  logic                  req_take;
  logic                  rsp_free;
  logic [VALUE_BITS-1:0] sample_ext;
  logic [LW-1:0]         tl_ext;
  logic [LEN_W-1:0]      len_calc;

  scan_ctl_t             scan_ctl;
  scan_stat_t            scan_stat;
  logic                  scan_rd_en;
  logic [IDX_W-1:0]      scan_rd_addr;
  logic [IDX_W-1:0]      scan_nearest;
  logic [IDX_W-1:0]      scan_first_tie;

  logic                  entry_we;
  logic                  entry_re;
  logic [IDX_W-1:0]      entry_raddr;
  logic [VALUE_BITS-1:0] entry_rvalue;
  logic [ID_W-1:0]       entry_rid;

  logic                  mark_we;
  logic [ROW_W-1:0]      mark_waddr;
  logic [MARK_W-1:0]     mark_wdata;
  logic                  mark_re;
  logic [ROW_W-1:0]      mark_raddr;
  logic [MARK_W-1:0]     mark_rdata;
  logic                  mark_busy;

  logic [ROW_W-1:0]      row_inc;
  logic [BIT_W-1:0]      first_pos;
  logic [MARK_W-1:0]     first_onehot;
  logic [MARK_W-1:0]     rest;
  logic                  row_has;
  logic                  rest_has;
  logic                  row_last;
  logic [MARK_W-1:0]     range_mask;

  logic [EW-1:0] nl_e, nr_e, near_e, tie_e, lo_a, lo_e, hi_a, last_e, hi_e;

  assign req_stall  = (state != ST_IDLE) || mark_busy;
  assign req_take   = req_valid && !req_stall;
  assign rsp_free   = !rsp_valid || !rsp_stall;
  assign sample_ext = VALUE_BITS'(sample_value);

  assign tl_ext   = LW'(table_length);
  assign len_calc = (tl_ext >= LW'(TABLE_DEPTH)) ? LEN_W'(TABLE_DEPTH) : tl_ext[IDX_W:0];

  assign scan_ctl.start = req_take && (req_type == REQ_QUERY);
  assign scan_ctl.run   = (state == ST_SCAN);

  assign row_inc      = row + 1'b1;
  assign row_has      = |mark_rdata;
  assign first_onehot = MARK_W'(1) << first_pos;
  assign rest         = mark_rdata & ~first_onehot;
  assign rest_has     = |rest;
  assign row_last     = (row == '1);

  always_comb begin
    first_pos = '0;
    for (int b = MARK_W - 1; b >= 0; b--) begin
      if (mark_rdata[b]) begin
        first_pos = BIT_W'(b);
      end
    end
  end

  always_comb begin
    for (int b = 0; b < MARK_W; b++) begin
      range_mask[b] = ({row, BIT_W'(b)} >= lo) && ({row, BIT_W'(b)} <= hi);
    end
  end

  always_comb begin
    nl_e   = (EW'(left_neighbors) > EW'(MAX_SIDE)) ? EW'(MAX_SIDE) : EW'(left_neighbors);
    nr_e   = (EW'(right_neighbors) > EW'(MAX_SIDE)) ? EW'(MAX_SIDE) : EW'(right_neighbors);
    near_e = EW'(scan_nearest);
    tie_e  = EW'(scan_first_tie);
    lo_a   = (near_e >= nl_e) ? (near_e - nl_e) : '0;
    lo_e   = (scan_stat.tie && (tie_e < lo_a)) ? tie_e : lo_a;
    hi_a   = near_e + nr_e;
    last_e = EW'(len) - 1'b1;
    hi_e   = (hi_a < last_e) ? hi_a : last_e;
  end

  always_comb begin
    mark_we    = 1'b0;
    mark_waddr = row;
    mark_wdata = mark_rdata;
    mark_re    = 1'b0;
    mark_raddr = row;
    case (state)
      ST_IDLE: begin
        if (req_take && (req_type == REQ_DRAIN)) begin
          mark_re    = 1'b1;
          mark_raddr = drain_row;
        end
      end
      ST_MARK_RD: begin
        mark_re = 1'b1;
      end
      ST_MARK_WR: begin
        mark_we    = 1'b1;
        mark_wdata = mark_rdata | range_mask;
      end
      ST_FIND: begin
        if (row_has) begin
          mark_we    = 1'b1;
          mark_wdata = rest;
        end
        if (!(row_has && rest_has) && !row_last) begin
          mark_re    = 1'b1;
          mark_raddr = row_inc;
        end
      end
      ST_MORE: begin
        if (!row_has && !row_last) begin
          mark_re    = 1'b1;
          mark_raddr = row_inc;
        end
      end
      default: begin
      end
    endcase
  end

  assign entry_we    = req_take && (req_type == REQ_LOAD);
  assign entry_re    = scan_rd_en || ((state == ST_FIND) && row_has);
  assign entry_raddr = (state == ST_FIND) ? {row, first_pos} : scan_rd_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      left_neighbors  <= LEFT_RESET;
      right_neighbors <= RIGHT_RESET;
      table_length    <= LENGTH_RESET;
      load_ptr        <= '0;
      drain_row       <= '0;
      rsp_valid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_LEFT:   left_neighbors  <= cfg_data[SIDE_W-1:0];
          CFG_RIGHT:  right_neighbors <= cfg_data[SIDE_W-1:0];
          CFG_LENGTH: table_length    <= cfg_data[LENGTH_W-1:0];
          default: begin
          end
        endcase
      end
      if (rsp_valid && !rsp_stall && (state != ST_RESULT)) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (req_take) begin
            case (req_type)
              REQ_LOAD: begin
                load_ptr <= (load_ptr == LAST_IDX) ? '0 : load_ptr + 1'b1;
              end
              REQ_QUERY: begin
                drain_row <= '0;
                state     <= (len_calc == '0) ? ST_RESULT : ST_SCAN;
              end
              REQ_DRAIN: begin
                state <= ST_FIND;
              end
              default: begin
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (scan_stat.stop) begin
            state <= ST_RANGE;
          end
        end
        ST_RANGE: begin
          state <= ST_MARK_RD;
        end
        ST_MARK_RD: begin
          state <= ST_MARK_WR;
        end
        ST_MARK_WR: begin
          state <= (row == hi[IDX_W-1:BIT_W]) ? ST_RESULT : ST_MARK_RD;
        end
        ST_FIND: begin
          if (row_has) begin
            drain_row <= row;
            state     <= (rest_has || row_last) ? ST_RESULT : ST_MORE;
          end else if (row_last) begin
            drain_row <= '0;
            state     <= ST_RESULT;
          end
        end
        ST_MORE: begin
          if (row_has || row_last) begin
            state <= ST_RESULT;
          end
        end
        ST_RESULT: begin
          if (rsp_free) begin
            rsp_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (req_take) begin
          len       <= len_calc;
          res_kind  <= (req_type == REQ_QUERY) ? RES_QUERY : RES_DRAIN;
          res_idx   <= '0;
          res_found <= 1'b0;
          res_more  <= 1'b0;
          row       <= drain_row;
        end
      end
      ST_RANGE: begin
        lo      <= lo_e[IDX_W-1:0];
        hi      <= hi_e[IDX_W-1:0];
        row     <= lo_e[IDX_W-1:BIT_W];
        res_idx <= scan_nearest;
      end
      ST_MARK_WR: begin
        row <= row_inc;
      end
      ST_FIND: begin
        if (row_has) begin
          res_found <= 1'b1;
          res_idx   <= {row, first_pos};
          res_more  <= rest_has;
        end
        row <= row_inc;
      end
      ST_MORE: begin
        if (row_has) begin
          res_more <= 1'b1;
        end
        row <= row_inc;
      end
      ST_RESULT: begin
        if (rsp_free) begin
          result_kind   <= res_kind;
          nearest_index <= NEAREST_W'(res_idx);
          match_id      <= res_found ? entry_rid : '0;
          match_valid   <= res_found;
          last_match    <= (res_kind == RES_DRAIN) && !res_more;
        end
      end
      default: begin
      end
    endcase
  end

  nnm_entry_ram #(
    .DEPTH      (TABLE_DEPTH),
    .IDX_W      (IDX_W),
    .VALUE_BITS (VALUE_BITS)
  ) u_entry_ram (
    .clk    (clk),
    .we     (entry_we),
    .waddr  (load_ptr),
    .wvalue (sample_ext),
    .wid    (entry_id),
    .re     (entry_re),
    .raddr  (entry_raddr),
    .rvalue (entry_rvalue),
    .rid    (entry_rid)
  );

  nnm_mark_ram #(
    .ROW_W  (ROW_W),
    .MARK_W (MARK_W)
  ) u_mark_ram (
    .clk   (clk),
    .rst   (rst),
    .we    (mark_we),
    .waddr (mark_waddr),
    .wdata (mark_wdata),
    .re    (mark_re),
    .raddr (mark_raddr),
    .rdata (mark_rdata),
    .busy  (mark_busy)
  );

  nnm_scan #(
    .IDX_W      (IDX_W),
    .VALUE_BITS (VALUE_BITS)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .ctl       (scan_ctl),
    .len       (len),
    .query     (sample_ext),
    .rvalue    (entry_rvalue),
    .rd_en     (scan_rd_en),
    .rd_addr   (scan_rd_addr),
    .stat      (scan_stat),
    .nearest   (scan_nearest),
    .first_tie (scan_first_tie)
  );

  `NNM_ASSERT(a_clear_holds_req, clk, rst, mark_busy |-> req_stall, "request taken while marks clear")
  `NNM_ASSERT(a_rsp_from_result, clk, rst, $rose(rsp_valid) |-> $past(state == ST_RESULT), "result raised outside final step")
  `NNM_ASSERT(a_mark_rmw_order, clk, rst, (state == ST_MARK_WR) |-> $past(state == ST_MARK_RD), "mark write without preceding read")

endmodule

@@ test/tb_nearest_neighbor_match_marker_unit.sv @@
// ----------------------------------------------------------------------------
// Nearest neighbor match marker testbench
// Loads a sorted control table, runs nearest-value queries and drains the
// marked entries under many neighbor and length settings. Every result is
// checked against a behavioral copy of the table, its marks and pointers.
// The sender works in bursts and the receiver stalls on its own pattern,
// including long hold-offs that back the block up into its request side.
// ----------------------------------------------------------------------------
module tb_nearest_neighbor_match_marker_unit;
  import nnm_pkg::*;

  localparam int DEPTH = TABLE_DEPTH_DEF;
  localparam int SIDE_MAX = MAX_SIDE_DEF;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 40;
  localparam longint VALUE_MIN = -(longint'(1) << 31);
  localparam longint VALUE_MAX = (longint'(1) << 31) - 1;
  localparam logic [REQ_TYPE_W-1:0] REQ_RESERVED = 2'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_RESERVED = 2'd3;

  typedef struct {
    logic [REQ_TYPE_W-1:0] kind;
    logic signed [SAMPLE_W-1:0] value;
    logic [ID_W-1:0] id;
  } request_t;

  typedef struct {
    logic kind;
    logic [NEAREST_W-1:0] nearest;
    logic [ID_W-1:0] id;
    logic found;
    logic last;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  logic [REQ_TYPE_W-1:0] req_type = REQ_LOAD;
  logic signed [SAMPLE_W-1:0] sample_value = '0;
  logic [ID_W-1:0] entry_id = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  logic result_kind;
  logic [NEAREST_W-1:0] nearest_index;
  logic [ID_W-1:0] match_id;
  logic match_valid;
  logic last_match;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = CFG_LEFT;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  nearest_neighbor_match_marker_unit dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req_type(req_type),
    .sample_value(sample_value),
    .entry_id(entry_id),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .result_kind(result_kind),
    .nearest_index(nearest_index),
    .match_id(match_id),
    .match_valid(match_valid),
    .last_match(last_match),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Behavioral copy of the block state.
  logic signed [SAMPLE_W-1:0] tbl_value [DEPTH];
  logic [ID_W-1:0] tbl_id [DEPTH];
  bit tbl_mark [DEPTH];
  int load_ptr = 0;
  int drain_ptr = 0;
  int unsigned left_cnt = LEFT_RESET;
  int unsigned right_cnt = RIGHT_RESET;
  int unsigned length_cnt = LENGTH_RESET;

  // Generator view of the table contents, running ahead of acceptance.
  logic signed [SAMPLE_W-1:0] gen_value [DEPTH];
  int gen_ptr = 0;
  longint fill_value [DEPTH];

  request_t request_queue [$];
  answer_t answer_queue [$];
  request_t offered;
  answer_t head_answer;
  int issued_count = 0;
  int accepted_count = 0;
  int random_items = 0;
  int error_count = 0;
  int answers_seen = 0;
  int burst_left = 0;
  int gap_left = 0;
  int hold_left = 0;
  int next_hold_at = 60;
  int pattern_left = 0;
  int pattern_mode = 0;
  int unsigned cycle_count = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic longint value_gap(logic signed [SAMPLE_W-1:0] a,
                                       logic signed [SAMPLE_W-1:0] b);
    longint diff;
    diff = longint'(a) - longint'(b);
    return (diff < 0) ? -diff : diff;
  endfunction

  function automatic void check_field(string name, longint unsigned want,
                                      longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      error_count++;
    end
  endfunction

  task automatic update_match_table(request_t r);
    int len, j, k, i, nearest, nl, nr;
    longint best, d;
    bit have, done, more;
    answer_t ans;
    ans.kind = RES_QUERY;
    ans.nearest = '0;
    ans.id = '0;
    ans.found = 1'b0;
    ans.last = 1'b0;
    if (r.kind == REQ_LOAD) begin
      tbl_value[load_ptr] = r.value;
      tbl_id[load_ptr] = r.id;
      load_ptr = (load_ptr + 1) % DEPTH;
    end else if (r.kind == REQ_QUERY) begin
      len = (length_cnt < DEPTH) ? length_cnt : DEPTH;
      nearest = 0;
      best = 0;
      have = 1'b0;
      done = 1'b0;
      for (j = 0; j < len && !done; j++) begin
        d = value_gap(r.value, tbl_value[j]);
        if (!have || d < best || (d == 0 && best == 0)) begin
          have = 1'b1;
          best = d;
          nearest = j;
          if (d == 0) tbl_mark[j] = 1'b1;
        end else if (d > best) begin
          done = 1'b1;
        end
      end
      if (len > 0) begin
        nl = (left_cnt < SIDE_MAX) ? left_cnt : SIDE_MAX;
        nr = (right_cnt < SIDE_MAX) ? right_cnt : SIDE_MAX;
        tbl_mark[nearest] = 1'b1;
        for (k = 1; k <= nl && k <= nearest; k++) tbl_mark[nearest - k] = 1'b1;
        for (k = 1; k <= nr && nearest + k < len; k++) tbl_mark[nearest + k] = 1'b1;
      end
      drain_ptr = 0;
      ans.nearest = NEAREST_W'(nearest);
      answer_queue.push_back(ans);
    end else if (r.kind == REQ_DRAIN) begin
      ans.kind = RES_DRAIN;
      i = drain_ptr;
      while (i < DEPTH && !tbl_mark[i]) i++;
      if (i >= DEPTH) begin
        drain_ptr = 0;
        ans.last = 1'b1;
      end else begin
        tbl_mark[i] = 1'b0;
        more = 1'b0;
        for (j = i + 1; j < DEPTH && !more; j++) begin
          if (tbl_mark[j]) more = 1'b1;
        end
        drain_ptr = i + 1;
        ans.nearest = NEAREST_W'(i);
        ans.id = tbl_id[i];
        ans.found = 1'b1;
        ans.last = !more;
      end
      answer_queue.push_back(ans);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall) begin
        update_match_table(offered);
        accepted_count++;
      end
      if (!req_valid || !req_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          req_valid <= 1'b0;
        end else if (request_queue.size() > 0) begin
          offered = request_queue.pop_front();
          req_valid <= 1'b1;
          req_type <= offered.kind;
          sample_value <= offered.value;
          entry_id <= offered.id;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 60);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        answers_seen++;
        if (answer_queue.size() == 0) begin
          $error("unpredicted result: result_kind %0d nearest_index %0d match_id %0d",
                 result_kind, nearest_index, match_id);
          error_count++;
        end else begin
          head_answer = answer_queue.pop_front();
          check_field("result_kind", head_answer.kind, result_kind);
          check_field("nearest_index", head_answer.nearest, nearest_index);
          check_field("match_id", head_answer.id, match_id);
          check_field("match_valid", head_answer.found, match_valid);
          check_field("last_match", head_answer.last, last_match);
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else if (answers_seen >= next_hold_at) begin
        hold_left = 300;
        next_hold_at = next_hold_at + 400;
        rsp_stall <= 1'b1;
      end else begin
        if (pattern_left == 0) begin
          pattern_mode = $urandom_range(0, 3);
          pattern_left = $urandom_range(10, 150);
        end else begin
          pattern_left--;
        end
        if (pattern_mode == 0) rsp_stall <= 1'b0;
        else if (pattern_mode == 1) rsp_stall <= ($urandom_range(0, 3) == 0);
        else if (pattern_mode == 2) rsp_stall <= ($urandom_range(0, 3) != 0);
        else rsp_stall <= !rsp_stall;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("nearest_neighbor_match_marker_unit verification failed");
      $finish;
    end
  end

  task automatic queue_request(logic [REQ_TYPE_W-1:0] kind, longint v);
    request_t r;
    r.kind = kind;
    r.value = SAMPLE_W'(v);
    r.id = ID_W'($urandom);
    request_queue.push_back(r);
    issued_count++;
    if (kind != REQ_RESERVED) random_items++;
    if (kind == REQ_LOAD) begin
      gen_value[gen_ptr] = r.value;
      gen_ptr = (gen_ptr + 1) % DEPTH;
    end
  endtask

  // Keeps the table ascending by picking a value between the neighbors.
  task automatic queue_sorted_load();
    longint lo, hi, span, v;
    lo = (gen_ptr > 0) ? longint'(gen_value[gen_ptr - 1]) : VALUE_MIN;
    hi = (gen_ptr < DEPTH - 1) ? longint'(gen_value[gen_ptr + 1]) : VALUE_MAX;
    if (hi < lo) hi = lo;
    span = hi - lo;
    case ($urandom_range(0, 3))
      0: v = lo;
      1: v = hi;
      default: v = lo + longint'({$urandom, $urandom} % (span + 1));
    endcase
    queue_request(REQ_LOAD, v);
  endtask

  task automatic queue_query();
    int n, i, pick;
    longint v;
    n = (length_cnt < DEPTH) ? length_cnt : DEPTH;
    i = (n > 0) ? $urandom_range(0, n - 1) : 0;
    pick = $urandom_range(0, 7);
    if (pick <= 2) v = gen_value[i];
    else if (pick <= 4) v = longint'(gen_value[i]) + longint'($urandom_range(0, 6)) - 3;
    else if (pick == 5) v = longint'(int'($urandom));
    else if (pick == 6) v = ($urandom_range(0, 1) == 1) ? VALUE_MAX : VALUE_MIN;
    else if (i + 1 < n) v = (longint'(gen_value[i]) + longint'(gen_value[i + 1])) / 2;
    else v = gen_value[i];
    queue_request(REQ_QUERY, v);
  endtask

  task automatic write_register(logic [CFG_INDEX_W-1:0] idx, int unsigned data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(data);
    if (idx == CFG_LEFT) left_cnt = data & 'h1F;
    else if (idx == CFG_RIGHT) right_cnt = data & 'h1F;
    else if (idx == CFG_LENGTH) length_cnt = data & 'h7FF;
  endtask

  task automatic apply_settings(int unsigned l, int unsigned r, int unsigned len);
    write_register(CFG_LEFT, l);
    write_register(CFG_RIGHT, r);
    write_register(CFG_LENGTH, len);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (accepted_count != issued_count || answer_queue.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic int unsigned random_side();
    int pick;
    pick = $urandom_range(0, 5);
    if (pick == 0) return 0;
    if (pick == 1) return SIDE_MAX;
    if (pick == 2) return $urandom_range(SIDE_MAX + 1, 31);
    return $urandom_range(0, SIDE_MAX - 1);
  endfunction

  function automatic int unsigned random_length();
    int pick;
    pick = $urandom_range(0, 11);
    if (pick == 0) return 0;
    if (pick == 1) return 1;
    if (pick == 2) return $urandom_range(DEPTH - 1, DEPTH);
    if (pick == 3) return $urandom_range(DEPTH + 1, 2047);
    return $urandom_range(2, 48);
  endfunction

  initial begin
    int phase, steps, pick, k, nl, nr;
    int unsigned l, r, len;
    longint acc;

    foreach (tbl_mark[i]) tbl_mark[i] = 1'b0;
    foreach (gen_value[i]) gen_value[i] = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Empty table under the reset settings, then a small table with a
    // duplicated minimum and an exact tie in the middle.
    queue_request(REQ_QUERY, 0);
    queue_request(REQ_DRAIN, 0);
    queue_request(REQ_RESERVED, $urandom);
    queue_request(REQ_LOAD, VALUE_MIN);
    queue_request(REQ_LOAD, VALUE_MIN);
    queue_request(REQ_LOAD, -500);
    queue_request(REQ_LOAD, 0);
    queue_request(REQ_LOAD, 0);
    queue_request(REQ_LOAD, 7);
    queue_request(REQ_LOAD, 1000);
    queue_request(REQ_LOAD, VALUE_MAX);
    wait_idle();

    apply_settings(1, 31, 8);
    queue_request(REQ_QUERY, 0);
    queue_request(REQ_DRAIN, 0);
    queue_request(REQ_DRAIN, 0);
    queue_request(REQ_QUERY, VALUE_MAX);
    repeat (5) queue_request(REQ_DRAIN, 0);
    wait_idle();

    apply_settings(31, 0, 8);
    queue_request(REQ_QUERY, VALUE_MIN);
    queue_request(REQ_QUERY, -250);
    queue_request(REQ_DRAIN, 0);
    wait_idle();

    // Fill every entry with an ascending sequence that spans the value range.
    acc = VALUE_MIN + $urandom_range(0, 1000);
    for (k = 0; k < DEPTH; k++) begin
      if ($urandom_range(0, 15) != 0) acc = acc + $urandom_range(0, 8000000);
      if (acc > VALUE_MAX) acc = VALUE_MAX;
      fill_value[k] = acc;
    end
    for (k = 0; k < DEPTH; k++) queue_request(REQ_LOAD, fill_value[gen_ptr]);
    wait_idle();

    random_items = 0;
    phase = 0;
    while (random_items < 1000) begin
      if (phase == 0) begin
        l = 0;
        r = 0;
        len = DEPTH;
        write_register(CFG_RESERVED, $urandom_range(0, 2047));
      end else if (phase == 1) begin
        l = 31;
        r = 31;
        len = 2047;
      end else if (phase == 2) begin
        l = SIDE_MAX;
        r = SIDE_MAX;
        len = 1;
      end else begin
        l = random_side();
        r = random_side();
        len = random_length();
      end
      apply_settings(l, r, len);
      nl = (left_cnt < SIDE_MAX) ? left_cnt : SIDE_MAX;
      nr = (right_cnt < SIDE_MAX) ? right_cnt : SIDE_MAX;
      steps = (length_cnt >= 64) ? $urandom_range(3, 6) : $urandom_range(15, 30);
      repeat (steps) begin
        pick = $urandom_range(0, 19);
        if (pick <= 8) begin
          queue_query();
          repeat ($urandom_range(1, nl + nr + 5)) queue_request(REQ_DRAIN, $urandom);
        end else if (pick <= 13) begin
          repeat ($urandom_range(1, 4)) queue_sorted_load();
        end else if (pick == 14) begin
          queue_request(REQ_LOAD, longint'(int'($urandom)));
        end else if (pick <= 17) begin
          queue_request(REQ_DRAIN, $urandom);
        end else if (pick == 18) begin
          queue_request(REQ_RESERVED, $urandom);
        end else begin
          queue_query();
        end
      end
      wait_idle();
      phase++;
    end

    if (error_count == 0) begin
      $display("nearest_neighbor_match_marker_unit verification clean");
    end else begin
      $display("nearest_neighbor_match_marker_unit verification failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/nnm_pkg.sv
hdl/nnm_entry_ram.sv
hdl/nnm_mark_ram.sv
hdl/nnm_scan.sv
hdl/nearest_neighbor_match_marker_unit.sv
test/tb_nearest_neighbor_match_marker_unit.sv
